FILE: design/spms_pkg.sv
// Shared definitions for the shared-pool multi-stack unit.
// Field widths, operation and status codes, and default sizes.
// No dependencies.
package spms_pkg;

  // Default sizes
  localparam int DEF_NUM_STACKS   = 4;
  localparam int DEF_POOL_ENTRIES = 16;

  // Transaction field widths
  localparam int KIND_W   = 1;
  localparam int SID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 1'b0;
  localparam logic [KIND_W-1:0] KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: design/spms_ifs.sv
// Valid/ready channel interfaces for the shared-pool multi-stack unit.
// Depends on spms_pkg for the field widths.
interface spms_in_if import spms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [SID_W-1:0]         stack_id;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, stack_id, value, input ready);
  modport sink   (input valid, kind, stack_id, value, output ready);
endinterface

interface spms_out_if import spms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] popped_value;

  modport source (output valid, status, popped_value, input ready);
  modport sink   (input valid, status, popped_value, output ready);
endinterface

FILE: design/spms_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the pool entries and the stack top pointers. No dependencies.
module spms_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/shared_pool_multi_stack_unit.sv
// Top level of the shared-pool multi-stack unit: controller, free-list head
// and output register. Depends on spms_pkg, spms_ifs and spms_ram.
//
//  Channel   Direction  Handshake     Payload
//  in_if     sink       valid/ready   kind, stack_id, value
//  out_if    source     valid/ready   status, popped_value
//
// A push or a failing transaction passes S_IDLE and S_TOP; a successful pop
// also passes S_POOL, as the pool entry address comes out of the stack top
// memory read. After reset a clearing pass over every pool entry and stack
// builds the free list and empties every stack; no input is taken meanwhile.
// A new transaction is taken while the previous result waits in the output
// register; completion stalls only while that register is still full.
module shared_pool_multi_stack_unit import spms_pkg::*; #(
  parameter int NUM_STACKS   = DEF_NUM_STACKS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
  input logic         clk,
  input logic         rst_n,
  spms_in_if.sink     in_if,
  spms_out_if.source  out_if
);

  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam int PA_W   = $clog2(POOL_ENTRIES);
  localparam int TA_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CLR_N  = (POOL_ENTRIES > NUM_STACKS) ? POOL_ENTRIES : NUM_STACKS;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam int PW     = DATA_W + LINK_W;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_ENTRIES);

  // Controller states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_TOP   = 2'd2;
  localparam logic [1:0] S_POOL  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [CLR_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [LINK_W-1:0]        free_head_r, free_head_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [DATA_W-1:0]        out_value_r, out_value_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [TA_W-1:0]          sid_r, sid_nxt;
  logic                     sid_ok_r, sid_ok_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [PA_W-1:0]          pop_idx_r, pop_idx_nxt;

  // Memory ports
  logic              pool_we, pool_re;
  logic [PA_W-1:0]   pool_waddr, pool_raddr;
  logic [PW-1:0]     pool_wdata, pool_q;
  logic              top_we, top_re;
  logic [TA_W-1:0]   top_waddr, top_raddr;
  logic [LINK_W-1:0] top_wdata, top_q;

  logic [DATA_W-1:0] pr_data;
  logic [LINK_W-1:0] pr_link;
  logic              finish_ok;

  spms_ram #(.DEPTH(POOL_ENTRIES), .AW(PA_W), .W(PW)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .re    (pool_re),
    .raddr (pool_raddr),
    .rdata (pool_q)
  );

  spms_ram #(.DEPTH(NUM_STACKS), .AW(TA_W), .W(LINK_W)) u_top (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .re    (top_re),
    .raddr (top_raddr),
    .rdata (top_q)
  );

  assign pr_data   = pool_q[LINK_W +: DATA_W];
  assign pr_link   = pool_q[LINK_W-1:0];
  assign finish_ok = !out_valid_r || out_if.ready;

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.popped_value = out_value_r;

  // Controller: read, modify, write back
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    free_head_nxt  = free_head_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    kind_nxt       = kind_r;
    sid_nxt        = sid_r;
    sid_ok_nxt     = sid_ok_r;
    val_nxt        = val_r;
    pop_idx_nxt    = pop_idx_r;
    pool_we        = 1'b0;
    pool_waddr     = free_head_r[PA_W-1:0];
    pool_wdata     = {val_r, top_q};
    pool_re        = 1'b0;
    pool_raddr     = free_head_r[PA_W-1:0];
    top_we         = 1'b0;
    top_waddr      = sid_r;
    top_wdata      = free_head_r;
    top_re         = 1'b0;
    top_raddr      = TA_W'(in_if.stack_id);

    unique case (state_r)
      // Link every entry to the next one and empty every stack
      S_CLEAR: begin
        pool_we    = (32'(clr_cnt_r) < POOL_ENTRIES);
        pool_waddr = PA_W'(clr_cnt_r);
        pool_wdata = {{DATA_W{1'b0}}, LINK_W'(32'(clr_cnt_r) + 32'd1)};
        top_we     = (32'(clr_cnt_r) < NUM_STACKS);
        top_waddr  = TA_W'(clr_cnt_r);
        top_wdata  = LINK_NULL;
        if (32'(clr_cnt_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      // Take a transaction; read its stack top and the free-list head entry
      S_IDLE: begin
        if (in_if.valid) begin
          kind_nxt   = in_if.kind;
          sid_nxt    = TA_W'(in_if.stack_id);
          sid_ok_nxt = (32'(in_if.stack_id) < NUM_STACKS);
          val_nxt    = in_if.value;
          pool_re    = 1'b1;
          top_re     = 1'b1;
          state_nxt  = S_TOP;
        end
      end

      // Push completes here; pop either fails or reads the top entry
      S_TOP: begin
        if (kind_r == KIND_POP && sid_ok_r && top_q != LINK_NULL) begin
          pool_re     = 1'b1;
          pool_raddr  = top_q[PA_W-1:0];
          pop_idx_nxt = top_q[PA_W-1:0];
          state_nxt   = S_POOL;
        end else if (finish_ok) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          state_nxt     = S_IDLE;
          if (kind_r == KIND_POP) begin
            out_status_nxt = ST_EMPTY;
          end else if (!sid_ok_r || free_head_r == LINK_NULL) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_OK;
            pool_we        = 1'b1;
            top_we         = 1'b1;
            free_head_nxt  = pr_link;
          end
        end
      end

      // Pop: unlink the top entry and hand it back to the free list
      S_POOL: begin
        if (finish_ok) begin
          pool_we        = 1'b1;
          pool_waddr     = pop_idx_r;
          pool_wdata     = {pr_data, free_head_r};
          top_we         = 1'b1;
          top_wdata      = pr_link;
          free_head_nxt  = LINK_W'(pop_idx_r);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = pr_data;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    kind_r       <= kind_nxt;
    sid_r        <= sid_nxt;
    sid_ok_r     <= sid_ok_nxt;
    val_r        <= val_nxt;
    pop_idx_r    <= pop_idx_nxt;
  end

endmodule
